/* design/bfba_pkg.sv */
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types and constants for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

	localparam int DEF_MAX_BLOCKS = 16;
	localparam int DEF_SIZE_BITS  = 16;

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_LOAD    = 2'd1;
	localparam logic [1:0] OP_REQUEST = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] size_value;
	} cmd_t;

	typedef struct packed {
		logic        granted;
		logic [4:0]  block_position;
		logic [15:0] chosen_size;
	} result_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic mark;
	} cell_ctrl_t;

endpackage

/* design/bfba_cell.sv */
// ----------------------------------------------------------------------------
// bfba_cell
// One table entry plus one stage of the search chain.
// ----------------------------------------------------------------------------
module bfba_cell #(
	parameter int SIZE_BITS = 16,
	parameter int IDX_W     = 4,
	parameter int INDEX     = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bfba_pkg::cell_ctrl_t  ctrl,
	input  logic [IDX_W-1:0]      sel_idx,
	input  logic [SIZE_BITS-1:0]  load_size,
	input  logic [SIZE_BITS-1:0]  req_size,
	input  logic                  tok_valid_in,
	input  logic                  tok_found_in,
	input  logic [SIZE_BITS-1:0]  tok_size_in,
	input  logic [IDX_W-1:0]      tok_idx_in,
	output logic                  tok_valid_out,
	output logic                  tok_found_out,
	output logic [SIZE_BITS-1:0]  tok_size_out,
	output logic [IDX_W-1:0]      tok_idx_out
);
	import bfba_pkg::*;

	logic                 valid_q;
	logic                 used_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 tok_valid_q;
	logic                 tok_found_q;
	logic [SIZE_BITS-1:0] tok_size_q;
	logic [IDX_W-1:0]     tok_idx_q;
	logic                 hit;
	logic                 take;

	assign hit  = (sel_idx == IDX_W'(INDEX));
	// Strict less-than keeps the earliest entry on a tie.
	assign take = valid_q && !used_q && (size_q >= req_size) &&
	              (!tok_found_in || (size_q < tok_size_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			used_q  <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
			used_q  <= 1'b0;
		end else if (ctrl.mark && hit) begin
			used_q <= 1'b1;
		end else if (ctrl.load && hit) begin
			valid_q <= 1'b1;
			used_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && !ctrl.mark && hit) begin
			size_q <= load_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_valid_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_found_q <= tok_found_in || take;
		tok_size_q  <= take ? size_q : tok_size_in;
		tok_idx_q   <= take ? IDX_W'(INDEX) : tok_idx_in;
	end

	assign tok_valid_out = tok_valid_q;
	assign tok_found_out = tok_found_q;
	assign tok_size_out  = tok_size_q;
	assign tok_idx_out   = tok_idx_q;

endmodule

/* design/best_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a table of block sizes held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Present a command on cmd with start high; it is taken when busy is low.
//   Clear empties the table, load appends a free block (dropped when the table
//   is full); both give no result and leave busy low.
//   A request sends a search token down the chain of MAX_BLOCKS cells, one
//   cell per cycle, each keeping the smallest fitting free block seen so far.
//   busy stays high until the token leaves the tail; in the first cycle with
//   busy low done pulses for one cycle with result valid, and the chosen block
//   has already been marked used, so the next command may start in that cycle.
//   The receiver cannot stall: the result is only valid while done is high.
//   Reset empties the table and drops any search in flight.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
	parameter int MAX_BLOCKS = bfba_pkg::DEF_MAX_BLOCKS,
	parameter int SIZE_BITS  = bfba_pkg::DEF_SIZE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bfba_pkg::cmd_t    cmd,
	output logic              done,
	output bfba_pkg::result_t result
);
	import bfba_pkg::*;

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic                 state_q;
	logic [CNT_W-1:0]     count_q;
	logic                 done_q;
	result_t              result_q;
	logic [SIZE_BITS-1:0] req_q;

	logic                 accept;
	logic [SIZE_BITS+15:0] in_ext;
	logic [SIZE_BITS-1:0] in_size;
	logic [SIZE_BITS-1:0] req_size;
	cell_ctrl_t           ctrl;
	logic [IDX_W-1:0]     sel_idx;

	logic                 tv [MAX_BLOCKS+1];
	logic                 tf [MAX_BLOCKS+1];
	logic [SIZE_BITS-1:0] ts [MAX_BLOCKS+1];
	logic [IDX_W-1:0]     ti [MAX_BLOCKS+1];

	logic                 tail_valid;
	logic [IDX_W:0]       pos;
	logic [IDX_W+5:0]     pos_ext;
	logic [SIZE_BITS+15:0] size_ext;

	assign accept  = start && !busy;
	assign in_ext  = {{SIZE_BITS{1'b0}}, cmd.size_value};
	assign in_size = in_ext[SIZE_BITS-1:0];
	// The head cell compares in the accepting cycle, before req_q is loaded.
	assign req_size = tv[0] ? in_size : req_q;

	assign tail_valid = tv[MAX_BLOCKS];

	always_comb begin
		ctrl.clear = accept && (cmd.opcode == OP_CLEAR);
		ctrl.load  = accept && (cmd.opcode == OP_LOAD) && (count_q < CNT_W'(MAX_BLOCKS));
		ctrl.mark  = tail_valid && tf[MAX_BLOCKS];
		sel_idx    = ctrl.mark ? ti[MAX_BLOCKS] : count_q[IDX_W-1:0];
	end

	// Token enters the head of the chain with nothing found yet.
	assign tv[0] = accept && (cmd.opcode == OP_REQUEST);
	assign tf[0] = 1'b0;
	assign ts[0] = '0;
	assign ti[0] = '0;

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		bfba_cell #(
			.SIZE_BITS (SIZE_BITS),
			.IDX_W     (IDX_W),
			.INDEX     (g)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.sel_idx       (sel_idx),
			.load_size     (in_size),
			.req_size      (req_size),
			.tok_valid_in  (tv[g]),
			.tok_found_in  (tf[g]),
			.tok_size_in   (ts[g]),
			.tok_idx_in    (ti[g]),
			.tok_valid_out (tv[g+1]),
			.tok_found_out (tf[g+1]),
			.tok_size_out  (ts[g+1]),
			.tok_idx_out   (ti[g+1])
		);
	end

	assign pos      = {1'b0, ti[MAX_BLOCKS]} + (IDX_W+1)'(1);
	assign pos_ext  = {5'd0, pos};
	assign size_ext = {16'd0, ts[MAX_BLOCKS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.clear) begin
				count_q <= '0;
			end else if (ctrl.load) begin
				count_q <= count_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tv[0]) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (tail_valid) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tv[0]) begin
			req_q <= in_size;
		end
		if (tail_valid) begin
			result_q.granted        <= tf[MAX_BLOCKS];
			result_q.block_position <= tf[MAX_BLOCKS] ? pos_ext[4:0] : 5'd0;
			result_q.chosen_size    <= tf[MAX_BLOCKS] ? size_ext[15:0] : 16'd0;
		end
	end

	assign busy   = (state_q == ST_SEARCH);
	assign done   = done_q;
	assign result = result_q;

endmodule
